FILE: sv/esc_pkg.sv
// Shared types and constants for the EMA smoother and change detector.
`timescale 1ns / 1ps
`default_nettype none

package esc_pkg;

   // Fixed-point layout of the filter state: 16 integer bits, FRAC_BITS fraction bits.
   localparam int FRAC_BITS = 16;
   localparam int DATA_W    = 16;
   localparam int FILT_W    = DATA_W + FRAC_BITS;
   localparam int ALPHA_W   = 17;
   // Weighted sum before the Q1.16 scale is removed.
   localparam int SUM_W     = ALPHA_W + FILT_W;
   localparam int CSR_IDX_W = 2;

   localparam logic [ALPHA_W-1:0] ONE_Q16      = ALPHA_W'(65536);
   localparam logic [ALPHA_W-1:0] ALPHA_RESET  = ALPHA_W'(19661);
   localparam logic [DATA_W-1:0]  THRESH_RESET = DATA_W'(10);

   typedef enum logic [1:0] {
      CMD_LOAD   = 2'd0,
      CMD_UPDATE = 2'd1,
      CMD_CHECK  = 2'd2,
      CMD_NOP    = 2'd3
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ALPHA       = 2'd0,
      CSR_PROX_THR    = 2'd1,
      CSR_AMBIENT_THR = 2'd2,
      CSR_WHITE_THR   = 2'd3
   } csr_index_type;

   typedef struct packed {
      cmd_type            cmd;
      logic [DATA_W-1:0]  prox_raw;
      logic [DATA_W-1:0]  ambient_raw;
      logic [DATA_W-1:0]  white_raw;
      logic               prox_valid;
      logic               ambient_valid;
      logic               white_valid;
   } req_type;

   typedef struct packed {
      logic [DATA_W-1:0]  proximity;
      logic [DATA_W-1:0]  ambient;
      logic [DATA_W-1:0]  white;
      logic               any_changed;
      logic               prox_changed;
      logic               ambient_changed;
      logic               white_changed;
   } rsp_type;

   // Configuration as seen by the channels; alpha is already saturated to 1.0.
   typedef struct packed {
      logic [ALPHA_W-1:0] alpha;
      logic [DATA_W-1:0]  prox_thr;
      logic [DATA_W-1:0]  ambient_thr;
      logic [DATA_W-1:0]  white_thr;
   } cfg_type;

   // Per-word control shared by all channels.
   typedef struct packed {
      logic    fire;
      cmd_type cmd;
      logic    started;
   } ctl_type;

endpackage

`default_nettype wire

FILE: sv/ema_smoother_change_detect_top.sv
// Top level of the three-channel EMA smoother with deadband change detection.
`timescale 1ns / 1ps
`default_nettype none

// The block takes one command word per cycle unless rsp_stall holds a full
// result register, and returns exactly one result word for each. A word
// accepted is held in the input register, processed there by the channels,
// and its result is captured in the result register. That rate is set by
// the per-channel filter datapath: each of the three channels has its own
// pair of multipliers (new-sample weight times raw value, old-sample weight
// times filter state) and computes its next state combinationally ahead of
// its state register, so a command may depend on the state left by the
// command just before it. A load command seeds each channel whose valid bit
// is set and marks the block started; an update command filters the valid
// channels once started; a check command compares each reported value
// against its reference and threshold, raises the change flags and moves
// the reference of each channel that changed. Configuration writes on the
// csr_ port are meant to happen while no word is in flight. The result
// register holds its word while rsp_stall is high, and the input register
// keeps accepting while it is empty or the result side can move.
module ema_smoother_change_detect_top (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  esc_pkg::req_type                   req_data,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output esc_pkg::rsp_type                   rsp_data,
   input  wire logic                          csr_wen,
   input  wire logic [esc_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [esc_pkg::ALPHA_W-1:0]   csr_wdata
);
   import esc_pkg::*;

   logic    in_valid_ff;
   req_type in_ff;
   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;
   rsp_type rsp_data_in;
   logic    started_ff;
   logic    started_in;
   logic    out_ready;
   cfg_type cfg;
   ctl_type ctl;

   // The result register can take a word when it is empty or being drained.
   assign out_ready = !rsp_valid_ff || !rsp_stall;
   assign req_stall = in_valid_ff && !out_ready;

   assign ctl.fire    = in_valid_ff && out_ready;
   assign ctl.cmd     = in_ff.cmd;
   assign ctl.started = started_ff;

   assign started_in = started_ff || (in_ff.cmd == CMD_LOAD);

   esc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   esc_channel u_prox (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .alpha     (cfg.alpha),
      .threshold (cfg.prox_thr),
      .raw       (in_ff.prox_raw),
      .raw_valid (in_ff.prox_valid),
      .value     (rsp_data_in.proximity),
      .changed   (rsp_data_in.prox_changed)
   );

   esc_channel u_ambient (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .alpha     (cfg.alpha),
      .threshold (cfg.ambient_thr),
      .raw       (in_ff.ambient_raw),
      .raw_valid (in_ff.ambient_valid),
      .value     (rsp_data_in.ambient),
      .changed   (rsp_data_in.ambient_changed)
   );

   esc_channel u_white (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .alpha     (cfg.alpha),
      .threshold (cfg.white_thr),
      .raw       (in_ff.white_raw),
      .raw_valid (in_ff.white_valid),
      .value     (rsp_data_in.white),
      .changed   (rsp_data_in.white_changed)
   );

   assign rsp_data_in.any_changed = rsp_data_in.prox_changed
                                  | rsp_data_in.ambient_changed
                                  | rsp_data_in.white_changed;

   // Input register: refills whenever its word moves on or it is empty.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   // The held word is cleared at reset so the command decode never sees an unknown code.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_ff <= '0;
      end else if (!req_stall && req_valid) begin
         in_ff <= req_data;
      end
   end

   // Result register and the started flag, both advanced with the word.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         started_ff   <= 1'b0;
      end else begin
         if (out_ready) rsp_valid_ff <= in_valid_ff;
         if (ctl.fire)  started_ff   <= started_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // A word that is not a check must never raise a change flag.
   a_flags_only_on_check : assert property (@(posedge clock) disable iff (reset)
      ctl.fire && (in_ff.cmd != CMD_CHECK) |=>
         !rsp_data_ff.any_changed && !rsp_data_ff.prox_changed
         && !rsp_data_ff.ambient_changed && !rsp_data_ff.white_changed)
      else $error("change flag raised by a non-check word");

   // A processed load always leaves the block started.
   a_load_starts : assert property (@(posedge clock) disable iff (reset)
      ctl.fire && (in_ff.cmd == CMD_LOAD) |=> started_ff)
      else $error("load did not set started");

   // Every processed word shows up as a valid result in the next cycle.
   a_fire_gives_result : assert property (@(posedge clock) disable iff (reset)
      ctl.fire |=> rsp_valid_ff)
      else $error("processed word produced no result");

   // Back-pressure only appears while a word sits in the input register.
   a_stall_needs_word : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff && rsp_valid_ff)
      else $error("input stalled without a pending word");

endmodule

`default_nettype wire

FILE: sv/esc_csr.sv
// Configuration registers: smoothing weight and per-channel thresholds.
`timescale 1ns / 1ps
`default_nettype none

module esc_csr (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_wen,
   input  wire logic [esc_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [esc_pkg::ALPHA_W-1:0]   csr_wdata,
   output esc_pkg::cfg_type                   cfg
);
   import esc_pkg::*;

   logic [ALPHA_W-1:0] alpha_ff;
   logic [DATA_W-1:0]  prox_thr_ff;
   logic [DATA_W-1:0]  ambient_thr_ff;
   logic [DATA_W-1:0]  white_thr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff       <= ALPHA_RESET;
         prox_thr_ff    <= THRESH_RESET;
         ambient_thr_ff <= THRESH_RESET;
         white_thr_ff   <= THRESH_RESET;
      end else if (csr_wen) begin
         unique case (csr_index_type'(csr_index))
            CSR_ALPHA:       alpha_ff       <= csr_wdata;
            CSR_PROX_THR:    prox_thr_ff    <= csr_wdata[DATA_W-1:0];
            CSR_AMBIENT_THR: ambient_thr_ff <= csr_wdata[DATA_W-1:0];
            CSR_WHITE_THR:   white_thr_ff   <= csr_wdata[DATA_W-1:0];
         endcase
      end
   end

   // Weights above one are clamped so the old-sample weight never goes negative.
   assign cfg.alpha       = (alpha_ff > ONE_Q16) ? ONE_Q16 : alpha_ff;
   assign cfg.prox_thr    = prox_thr_ff;
   assign cfg.ambient_thr = ambient_thr_ff;
   assign cfg.white_thr   = white_thr_ff;

endmodule

`default_nettype wire

FILE: sv/esc_channel.sv
// One sensor channel: EMA filter state, change reference and deadband compare.
`timescale 1ns / 1ps
`default_nettype none

module esc_channel (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  esc_pkg::ctl_type                 ctl,
   input  wire logic [esc_pkg::ALPHA_W-1:0] alpha,
   input  wire logic [esc_pkg::DATA_W-1:0]  threshold,
   input  wire logic [esc_pkg::DATA_W-1:0]  raw,
   input  wire logic                        raw_valid,
   output logic [esc_pkg::DATA_W-1:0]       value,
   output logic                             changed
);
   import esc_pkg::*;

   logic [FILT_W-1:0]  filter_ff;
   logic [FILT_W-1:0]  filter_in;
   logic [DATA_W-1:0]  reference_ff;
   logic [DATA_W-1:0]  reference_in;

   logic [ALPHA_W-1:0]        alpha_rest;
   logic [ALPHA_W+DATA_W-1:0] new_prod;
   logic [SUM_W-1:0]          old_prod;
   logic [SUM_W-1:0]          sum;
   logic [DATA_W-1:0]         current;
   logic [DATA_W-1:0]         diff;
   logic                      hit;

   // Weighted sum of the new sample and the old state, both at the filter's scale.
   assign alpha_rest = ONE_Q16 - alpha;
   assign new_prod   = (ALPHA_W+DATA_W)'(alpha) * (ALPHA_W+DATA_W)'(raw);
   assign old_prod   = SUM_W'(alpha_rest) * SUM_W'(filter_ff);
   assign sum        = {new_prod, {FRAC_BITS{1'b0}}} + old_prod;

   assign current = filter_ff[FRAC_BITS +: DATA_W];
   assign diff    = (current >= reference_ff) ? (current - reference_ff)
                                              : (reference_ff - current);
   assign hit     = (diff >= threshold);

   always_comb begin
      filter_in    = filter_ff;
      reference_in = reference_ff;
      changed      = 1'b0;
      unique case (ctl.cmd)
         CMD_LOAD: begin
            if (raw_valid) filter_in = {raw, {FRAC_BITS{1'b0}}};
         end
         CMD_UPDATE: begin
            if (ctl.started && raw_valid) filter_in = sum[16 +: FILT_W];
         end
         CMD_CHECK: begin
            changed = hit;
            if (hit) reference_in = current;
         end
         CMD_NOP: begin
         end
      endcase
   end

   assign value = filter_in[FRAC_BITS +: DATA_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         filter_ff    <= '0;
         reference_ff <= '0;
      end else if (ctl.fire) begin
         filter_ff    <= filter_in;
         reference_ff <= reference_in;
      end
   end

endmodule

`default_nettype wire
